>>> sv/sparse_matrix_vector_engine_assert.svh
// ----------------------------------------------------------------------------
// sparse matrix vector engine assertion macros
// concurrent check shorthands used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_VECTOR_ENGINE_ASSERT_SVH
`define SPARSE_MATRIX_VECTOR_ENGINE_ASSERT_SVH

// same-cycle implication
`define SPMV_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPMV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/spmv_pkg.sv
// ----------------------------------------------------------------------------
// spmv_pkg
// shared constants, codes and control structs of the sparse matrix engine
// ----------------------------------------------------------------------------
package spmv_pkg;

	localparam int MAX_DIM     = 64;
	localparam int MAX_ENTRIES = 256;
	localparam int VALUE_BITS  = 32;

	localparam int CMD_W     = 3;
	localparam int ROW_W     = 6;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int DIM_CNT_W = 7;
	localparam int THR_W     = 31;
	localparam int X_AW      = $clog2(MAX_DIM);
	localparam int ENTRY_AW  = $clog2(MAX_ENTRIES);
	localparam int COUNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_W   = 2 * ROW_W + VALUE_BITS;
	localparam int PADDR_W   = 4;
	localparam int ACC_W     = 64;
	localparam int PROD_W    = VALUE_BITS + DATA_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR    = 3'd0,
		CMD_ADD      = 3'd1,
		CMD_WRITE_X  = 3'd2,
		CMD_MULTIPLY = 3'd3,
		CMD_DIAGONAL = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_NUM_ROWS       = 2'd0,
		REG_NUM_COLUMNS    = 2'd1,
		REG_DROP_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ACK,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SCAN_RD,
		S_SCAN_X,
		S_SCAN_MUL,
		S_SCAN_ACC,
		S_ROW_OUT
	} state_t;

	typedef struct packed {
		logic [DIM_CNT_W-1:0] num_rows;
		logic [DIM_CNT_W-1:0] num_columns;
		logic [THR_W-1:0]     drop_threshold;
	} cfg_t;

	typedef struct packed {
		logic                capture;
		logic                entry_rd;
		logic [ENTRY_AW-1:0] entry_addr;
		logic                merge_wr;
		logic                append_wr;
		logic                clear_count;
		logic                x_wr;
		logic                x_rd;
		logic                term_ld;
		logic                acc_clr;
		logic                acc_add;
		logic                emit_ack;
		status_t             ack_status;
		logic                emit_row;
		logic [ROW_W-1:0]    row;
		logic                row_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic                 range_err;
		logic                 hit;
		logic                 full;
		logic [COUNT_W-1:0]   count;
		logic [DIM_CNT_W-1:0] nr_eff;
		logic                 out_free;
	} dp_stat_t;

endpackage

>>> sv/spmv_in_if.sv
// ----------------------------------------------------------------------------
// spmv_in_if
// request channel of the sparse matrix engine
// ----------------------------------------------------------------------------
interface spmv_in_if;
	import spmv_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [ROW_W-1:0]         row_index;
	logic [ROW_W-1:0]         column_index;
	logic signed [DATA_W-1:0] operand_value;

	modport source (output valid, output cmd, output row_index, output column_index,
		output operand_value, input ready);
	modport sink (input valid, input cmd, input row_index, input column_index,
		input operand_value, output ready);
endinterface

>>> sv/spmv_out_if.sv
// ----------------------------------------------------------------------------
// spmv_out_if
// result channel of the sparse matrix engine
// ----------------------------------------------------------------------------
interface spmv_out_if;
	import spmv_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ROW_W-1:0]         out_row;
	logic signed [DATA_W-1:0] out_value;
	logic                     last;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, output out_row, output out_value, output last,
		output status, input ready);
	modport sink (input valid, input out_row, input out_value, input last,
		input status, output ready);
endinterface

>>> sv/sparse_matrix_vector_engine.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_engine
// merged coordinate sparse matrix store with Q16.16 multiply by x and
// diagonal readout, apb configuration
// ----------------------------------------------------------------------------
// One request is taken at a time. An add searches the stored entries
// serially through the single-port entry store before it merges or
// appends. Multiply and diagonal scan the whole store for every row, with
// an entry read, x read, multiply and accumulate step for each entry. A held
// result register stretches any of these while the result channel is stalled.
`include "sparse_matrix_vector_engine_assert.svh"

module sparse_matrix_vector_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	spmv_in_if.sink                      in_ch,
	spmv_out_if.source                   out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spmv_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import spmv_pkg::*;

	cfg_t     cfg_q;
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_NUM_ROWS:       cfg_q.num_rows       <= pwdata[DIM_CNT_W-1:0];
				REG_NUM_COLUMNS:    cfg_q.num_columns    <= pwdata[DIM_CNT_W-1:0];
				REG_DROP_THRESHOLD: cfg_q.drop_threshold <= pwdata[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_NUM_ROWS:       prdata = 32'(cfg_q.num_rows);
			REG_NUM_COLUMNS:    prdata = 32'(cfg_q.num_columns);
			REG_DROP_THRESHOLD: prdata = 32'(cfg_q.drop_threshold);
			default:            prdata = '0;
		endcase
	end

	spmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	spmv_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.cmd              (dp_cmd),
		.stat             (dp_stat),
		.in_cmd           (in_ch.cmd),
		.in_row_index     (in_ch.row_index),
		.in_column_index  (in_ch.column_index),
		.in_operand_value (in_ch.operand_value),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_row          (out_ch.out_row),
		.out_value        (out_ch.out_value),
		.out_last         (out_ch.last),
		.out_status       (out_ch.status)
	);

	`SPMV_ASSERT_NEXT(a_one_request, in_ch.valid && in_ch.ready, !in_ch.ready, "request overlap")
	`SPMV_ASSERT_SAME(a_err_last, out_ch.valid && out_ch.status != ST_OK, out_ch.last, "error not last")
	`SPMV_ASSERT_SAME(a_err_zero, out_ch.valid && out_ch.status != ST_OK, out_ch.out_value == 0, "error value")
	`SPMV_ASSERT_SAME(a_count_max, 1'b1, dp_stat.count <= COUNT_W'(MAX_ENTRIES), "count overflow")
endmodule

>>> sv/spmv_ram.sv
// ----------------------------------------------------------------------------
// spmv_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module spmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> sv/spmv_datapath.sv
// ----------------------------------------------------------------------------
// spmv_datapath
// request registers, entry and x stores, term multiplier, accumulator
// and result register
// ----------------------------------------------------------------------------
module spmv_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spmv_pkg::cfg_t                    cfg,
	input  spmv_pkg::dp_cmd_t                 cmd,
	output spmv_pkg::dp_stat_t                stat,
	input  logic [spmv_pkg::CMD_W-1:0]        in_cmd,
	input  logic [spmv_pkg::ROW_W-1:0]        in_row_index,
	input  logic [spmv_pkg::ROW_W-1:0]        in_column_index,
	input  logic signed [spmv_pkg::DATA_W-1:0] in_operand_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [spmv_pkg::ROW_W-1:0]        out_row,
	output logic signed [spmv_pkg::DATA_W-1:0] out_value,
	output logic                              out_last,
	output logic [spmv_pkg::STATUS_W-1:0]     out_status
);
	import spmv_pkg::*;

	function automatic logic signed [VALUE_BITS-1:0] sat_value(
		input logic signed [VALUE_BITS:0] s);
		logic signed [VALUE_BITS-1:0] r;
		if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
			r = s[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}} : {1'b0, {(VALUE_BITS-1){1'b1}}};
		end else begin
			r = s[VALUE_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [ACC_W-1:0] a);
		logic signed [DATA_W-1:0] r;
		if (a > ACC_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (a < ACC_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}))) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = a[DATA_W-1:0];
		end
		return r;
	endfunction

	logic [CMD_W-1:0]         cmd_q;
	logic [ROW_W-1:0]         row_q;
	logic [ROW_W-1:0]         col_q;
	logic signed [DATA_W-1:0] val_q;

	logic [COUNT_W-1:0]       count_q;
	logic [MAX_DIM-1:0]       x_valid_q;
	logic                     xvld_q;
	logic                     keep_q;
	logic signed [ACC_W-1:0]  term_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic                     out_valid_q;
	logic [ROW_W-1:0]         out_row_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic                     out_last_q;
	logic [STATUS_W-1:0]      out_status_q;

	logic [DIM_CNT_W-1:0]     nr_eff;
	logic [DIM_CNT_W-1:0]     nc_eff;

	logic                     ent_wr_en;
	logic [ENTRY_AW-1:0]      ent_wr_addr;
	logic [ENTRY_W-1:0]       ent_wr_data;
	logic [ENTRY_W-1:0]       ent_rd_data;
	logic [ROW_W-1:0]         e_row;
	logic [ROW_W-1:0]         e_col;
	logic signed [VALUE_BITS-1:0] e_val;
	logic signed [VALUE_BITS-1:0] val_ext;
	logic signed [VALUE_BITS-1:0] merged;
	logic signed [VALUE_BITS:0]   e_wide;
	logic [VALUE_BITS:0]      e_mag;
	logic                     keep;

	logic [DATA_W-1:0]        x_rd_data;
	logic signed [DATA_W-1:0] x_val;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [ACC_W:0]    acc_sum;
	logic signed [ACC_W-1:0]  acc_next;

	assign nr_eff = (cfg.num_rows > DIM_CNT_W'(MAX_DIM)) ? DIM_CNT_W'(MAX_DIM) : cfg.num_rows;
	assign nc_eff = (cfg.num_columns > DIM_CNT_W'(MAX_DIM)) ? DIM_CNT_W'(MAX_DIM)
		: cfg.num_columns;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_cmd;
			row_q <= in_row_index;
			col_q <= in_column_index;
			val_q <= in_operand_value;
		end
	end

	// entry store
	assign e_row   = ent_rd_data[ENTRY_W-1 -: ROW_W];
	assign e_col   = ent_rd_data[VALUE_BITS +: ROW_W];
	assign e_val   = signed'(ent_rd_data[VALUE_BITS-1:0]);
	assign val_ext = VALUE_BITS'(val_q);
	assign merged  = sat_value((VALUE_BITS+1)'(e_val) + (VALUE_BITS+1)'(val_ext));

	assign ent_wr_en   = cmd.merge_wr | cmd.append_wr;
	assign ent_wr_addr = cmd.append_wr ? count_q[ENTRY_AW-1:0] : cmd.entry_addr;
	assign ent_wr_data = {row_q, col_q, cmd.append_wr ? val_ext : merged};

	spmv_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
		.clk     (clk),
		.wr_en   (ent_wr_en),
		.wr_addr (ent_wr_addr),
		.wr_data (ent_wr_data),
		.rd_en   (cmd.entry_rd),
		.rd_addr (cmd.entry_addr),
		.rd_data (ent_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear_count) begin
			count_q <= '0;
		end else if (cmd.append_wr) begin
			count_q <= count_q + COUNT_W'(1);
		end
	end

	// x vector store
	spmv_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_x_ram (
		.clk     (clk),
		.wr_en   (cmd.x_wr),
		.wr_addr (col_q[X_AW-1:0]),
		.wr_data (val_q),
		.rd_en   (cmd.x_rd),
		.rd_addr (e_col[X_AW-1:0]),
		.rd_data (x_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_valid_q <= '0;
		end else if (cmd.x_wr) begin
			x_valid_q[col_q[X_AW-1:0]] <= 1'b1;
		end
	end

	// entry filter
	assign e_wide = (VALUE_BITS+1)'(e_val);
	assign e_mag  = e_wide[VALUE_BITS] ? unsigned'(-e_wide) : unsigned'(e_wide);
	assign keep   = (e_row == cmd.row) && ({1'b0, e_col} < nc_eff)
		&& (e_mag > (VALUE_BITS+1)'(cfg.drop_threshold))
		&& (cmd_q != CMD_DIAGONAL || e_col == cmd.row);

	always_ff @(posedge clk) begin
		if (cmd.x_rd) begin
			keep_q <= keep;
			xvld_q <= x_valid_q[e_col[X_AW-1:0]];
		end
	end

	// term and accumulate
	assign x_val   = xvld_q ? signed'(x_rd_data) : '0;
	assign prod    = PROD_W'(e_val) * PROD_W'(x_val);
	assign prod_sh = prod >>> 16;

	always_ff @(posedge clk) begin
		if (cmd.term_ld) begin
			if (!keep_q) begin
				term_q <= '0;
			end else if (cmd_q == CMD_DIAGONAL) begin
				term_q <= ACC_W'(e_val);
			end else begin
				term_q <= ACC_W'(prod_sh);
			end
		end
	end

	assign acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(term_q);
	always_comb begin
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_next = acc_sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ack || cmd.emit_row) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ack) begin
			out_row_q    <= (cmd_q == CMD_ADD) ? row_q : '0;
			out_value_q  <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= cmd.ack_status;
		end else if (cmd.emit_row) begin
			out_row_q    <= cmd.row;
			out_value_q  <= sat_out(acc_q);
			out_last_q   <= cmd.row_last;
			out_status_q <= ST_OK;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_row    = out_row_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

	// status to controller
	always_comb begin
		stat.cmd       = cmd_q;
		stat.range_err = (cmd_q == CMD_ADD)
			? (({1'b0, row_q} >= nr_eff) || ({1'b0, col_q} >= nc_eff))
			: ({1'b0, col_q} >= nc_eff);
		stat.hit       = (e_row == row_q) && (e_col == col_q);
		stat.full      = (count_q == COUNT_W'(MAX_ENTRIES));
		stat.count     = count_q;
		stat.nr_eff    = nr_eff;
		stat.out_free  = !out_valid_q;
	end
endmodule

>>> sv/spmv_ctrl.sv
// ----------------------------------------------------------------------------
// spmv_ctrl
// command sequencer: store search, row by row store scan and result issue
// ----------------------------------------------------------------------------
module spmv_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  spmv_pkg::dp_stat_t   stat,
	output spmv_pkg::dp_cmd_t    cmd
);
	import spmv_pkg::*;

	state_t               state_q, state_d;
	logic [COUNT_W-1:0]   i_q, i_d;
	logic [DIM_CNT_W-1:0] r_q, r_d;
	status_t              ack_q, ack_d;
	logic                 row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			r_q     <= '0;
			ack_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			r_q     <= r_d;
			ack_q   <= ack_d;
		end
	end

	assign row_last = (r_q + DIM_CNT_W'(1)) == stat.nr_eff;

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		r_d      = r_q;
		ack_d    = ack_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.entry_addr = i_q[ENTRY_AW-1:0];
		cmd.ack_status = ack_q;
		cmd.row        = r_q[ROW_W-1:0];
		cmd.row_last   = row_last;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.cmd) inside
					CMD_CLEAR: begin
						cmd.clear_count = 1'b1;
						ack_d           = ST_OK;
						state_d         = S_ACK;
					end
					CMD_ADD: begin
						if (stat.range_err) begin
							ack_d   = ST_RANGE;
							state_d = S_ACK;
						end else begin
							i_d     = '0;
							state_d = S_SRCH_RD;
						end
					end
					CMD_WRITE_X: begin
						if (stat.range_err) begin
							ack_d = ST_RANGE;
						end else begin
							cmd.x_wr = 1'b1;
							ack_d    = ST_OK;
						end
						state_d = S_ACK;
					end
					CMD_MULTIPLY, CMD_DIAGONAL: begin
						if (stat.nr_eff == '0) begin
							state_d = S_IDLE;
						end else begin
							i_d         = '0;
							r_d         = '0;
							cmd.acc_clr = 1'b1;
							state_d     = S_SCAN_RD;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_ACK: begin
				if (stat.out_free) begin
					cmd.emit_ack = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SRCH_RD: begin
				if (i_q == stat.count) begin
					if (stat.full) begin
						ack_d = ST_FULL;
					end else begin
						cmd.append_wr = 1'b1;
						ack_d         = ST_OK;
					end
					state_d = S_ACK;
				end else begin
					cmd.entry_rd = 1'b1;
					state_d      = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (stat.hit) begin
					cmd.merge_wr = 1'b1;
					ack_d        = ST_OK;
					state_d      = S_ACK;
				end else begin
					i_d     = i_q + COUNT_W'(1);
					state_d = S_SRCH_RD;
				end
			end
			S_SCAN_RD: begin
				if (i_q == stat.count) begin
					state_d = S_ROW_OUT;
				end else begin
					cmd.entry_rd = 1'b1;
					state_d      = S_SCAN_X;
				end
			end
			S_SCAN_X: begin
				cmd.x_rd = 1'b1;
				state_d  = S_SCAN_MUL;
			end
			S_SCAN_MUL: begin
				cmd.term_ld = 1'b1;
				state_d     = S_SCAN_ACC;
			end
			S_SCAN_ACC: begin
				cmd.acc_add = 1'b1;
				i_d         = i_q + COUNT_W'(1);
				state_d     = S_SCAN_RD;
			end
			S_ROW_OUT: begin
				if (stat.out_free) begin
					cmd.emit_row = 1'b1;
					if (row_last) begin
						state_d = S_IDLE;
					end else begin
						r_d         = r_q + DIM_CNT_W'(1);
						i_d         = '0;
						cmd.acc_clr = 1'b1;
						state_d     = S_SCAN_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
